/* rtl/sdp_pkg.sv */
// Shared types and constants of the stream direction prefetcher.
// No dependencies; imported by stream_direction_prefetcher_unit.
package sdp_pkg;

   localparam int CONF_W = 3;
   localparam int DEG_W = 3;
   localparam int CSR_IDX_W = 2;

   typedef logic [CONF_W-1:0] conf_type;
   typedef logic [DEG_W-1:0] deg_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   // saturating confidence ceiling and the farthest line ahead
   localparam conf_type CONF_MAX = 3'd7;
   localparam deg_type STREAM_DISTANCE = 3'd4;

   // register indexes; any other index is ignored
   localparam csr_idx_type CSR_THRESHOLD = 2'd0;
   localparam csr_idx_type CSR_DEGREE = 2'd1;

   localparam conf_type THRESHOLD_RESET = 3'd2;
   localparam deg_type DEGREE_RESET = 3'd2;

endpackage

/* rtl/stream_direction_prefetcher_unit.sv */
// Stream direction prefetcher: stream table scan, LRU update, prefetch issue.
// Depends on sdp_pkg.
//
//  port group | dir | handshake         | payload
//  -----------+-----+-------------------+--------------------------------------
//  req_       | in  | req_valid/stall   | req_line_addr
//  rsp_       | out | rsp_valid/stall   | rsp_prefetch_line_addr, rsp_last
//  csr_       | in  | csr_valid/ready   | csr_index, csr_wdata
//
// An item is accepted in the idle state, then one compare unit walks the stream table
// one entry per cycle through the single read port of the entry memory (a priming
// read comes first), then the update state updates ages and writes the entry, and a hit
// may then issue 0 to 4 prefetches, each held by any rsp_ stall. Synchronous active-high
// reset; ages come up as the entry index, all entries invalid, threshold 2, degree 2.
// req_stall is high while an item is in flight. Prefetches leave through an output
// register; a stall on rsp_ holds the issue sequence, and the next item may enter
// while the last prefetch waits.
module stream_direction_prefetcher_unit
   import sdp_pkg::*;
#(
   parameter int STREAM_ENTRIES = 64,
   parameter int PAGE_BITS = 6,
   parameter int REGION_BITS = 10,
   parameter int LINE_ADDR_BITS = 58
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [LINE_ADDR_BITS-1:0] req_line_addr,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [LINE_ADDR_BITS-1:0] rsp_prefetch_line_addr,
   output logic                      rsp_last,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  csr_idx_type               csr_index,
   input  logic [DEG_W-1:0]          csr_wdata
);

   localparam int IDX_W = $clog2(STREAM_ENTRIES);
   localparam int CNT_W = IDX_W + 1;
   localparam int REG_W = LINE_ADDR_BITS - REGION_BITS;
   localparam int ENTRY_W = REG_W + PAGE_BITS + 1 + CONF_W;
   localparam int ROOM_W = (PAGE_BITS > DEG_W) ? PAGE_BITS : DEG_W;
   localparam logic [IDX_W-1:0] AGE_MAX = IDX_W'(STREAM_ENTRIES - 1);
   localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(STREAM_ENTRIES);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   // entry memory: region, last offset, direction, confidence
   logic [ENTRY_W-1:0] entry_mem [STREAM_ENTRIES];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic mem_we;
   logic [IDX_W-1:0] mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;

   // LRU ages and valid bits: a row that rotates during the scan so entry j sits at
   // position 0 when its memory word is compared
   logic [IDX_W-1:0] age_ff [STREAM_ENTRIES];
   logic [IDX_W-1:0] age_in [STREAM_ENTRIES];
   logic [STREAM_ENTRIES-1:0] valid_ff, valid_in;
   logic [STREAM_ENTRIES-1:0] age_zero;

   logic [1:0] state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LINE_ADDR_BITS-1:0] line_ff, line_in;
   logic hit_ff, hit_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   logic [IDX_W-1:0] mine_ff, mine_in;
   logic [PAGE_BITS-1:0] hit_off_ff, hit_off_in;
   logic hit_desc_ff, hit_desc_in;
   conf_type hit_conf_ff, hit_conf_in;
   logic [IDX_W-1:0] victim_ff, victim_in;
   logic victim_seen_ff, victim_seen_in;
   deg_type n_ff, n_in;
   deg_type d_ff, d_in;
   conf_type thr_ff, thr_in;
   deg_type deg_ff, deg_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [LINE_ADDR_BITS-1:0] rsp_addr_ff, rsp_addr_in;
   logic rsp_last_ff, rsp_last_in;

   // scan compare
   logic [IDX_W-1:0] cmp_idx;
   logic [REG_W-1:0] rd_region;
   logic [PAGE_BITS-1:0] rd_off;
   logic rd_desc;
   conf_type rd_conf;
   logic [REG_W-1:0] line_region;
   logic [PAGE_BITS-1:0] line_off;

   // stream update
   logic asc, agrees, new_desc;
   conf_type new_conf;
   deg_type count;
   logic [PAGE_BITS-1:0] room;
   logic [ROOM_W-1:0] n_sel;
   logic load;
   logic [PAGE_BITS-1:0] target;

   assign line_region = line_ff[LINE_ADDR_BITS-1:REGION_BITS];
   assign line_off = line_ff[PAGE_BITS-1:0];
   assign {rd_region, rd_off, rd_desc, rd_conf} = rd_data_ff;
   assign cmp_idx = IDX_W'(cnt_ff - 1'b1);
   assign rd_addr = cnt_ff[IDX_W-1:0];

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_prefetch_line_addr = rsp_addr_ff;
   assign rsp_last = rsp_last_ff;

   // confidence and direction of the matched stream
   always_comb begin
      asc = line_off > hit_off_ff;
      agrees = asc ? !hit_desc_ff : hit_desc_ff;
      new_conf = hit_conf_ff;
      new_desc = hit_desc_ff;
      if (agrees) begin
         if (hit_conf_ff < CONF_MAX) new_conf = hit_conf_ff + 1'b1;
      end else if (hit_conf_ff != '0) begin
         new_conf = hit_conf_ff - 1'b1;
      end else begin
         new_desc = !asc;
      end
      count = (deg_ff > STREAM_DISTANCE) ? STREAM_DISTANCE : deg_ff;
      // lines left in the page in the stream direction
      room = new_desc ? line_off : ~line_off;
      n_sel = (ROOM_W'(room) < ROOM_W'(count)) ? ROOM_W'(room) : ROOM_W'(count);
   end

   assign load = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
   assign target = hit_desc_ff ? (line_off - PAGE_BITS'(d_ff)) : (line_off + PAGE_BITS'(d_ff));

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      line_in = line_ff;
      hit_in = hit_ff;
      hit_idx_in = hit_idx_ff;
      mine_in = mine_ff;
      hit_off_in = hit_off_ff;
      hit_desc_in = hit_desc_ff;
      hit_conf_in = hit_conf_ff;
      victim_in = victim_ff;
      victim_seen_in = victim_seen_ff;
      n_in = n_ff;
      d_in = d_ff;
      thr_in = thr_ff;
      deg_in = deg_ff;
      age_in = age_ff;
      valid_in = valid_ff;
      mem_we = 1'b0;
      mem_waddr = hit_idx_ff;
      mem_wdata = {line_region, line_off, 1'b0, conf_type'(0)};
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_addr_in = rsp_addr_ff;
      rsp_last_in = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_THRESHOLD: thr_in = csr_wdata;
            CSR_DEGREE: deg_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SCAN;
               line_in = req_line_addr;
               cnt_in = '0;
               hit_in = 1'b0;
               victim_seen_in = 1'b0;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff != '0) begin
               // entry cmp_idx sits at the head of the row
               if (!hit_ff && valid_ff[0] && rd_region == line_region) begin
                  hit_in = 1'b1;
                  hit_idx_in = cmp_idx;
                  mine_in = age_ff[0];
                  hit_off_in = rd_off;
                  hit_desc_in = rd_desc;
                  hit_conf_in = rd_conf;
               end
               if (age_ff[0] == AGE_MAX) begin
                  victim_in = cmp_idx;
                  victim_seen_in = 1'b1;
               end
               for (int i = 0; i < STREAM_ENTRIES - 1; i++) begin
                  age_in[i] = age_ff[i+1];
                  valid_in[i] = valid_ff[i+1];
               end
               age_in[STREAM_ENTRIES-1] = age_ff[0];
               valid_in[STREAM_ENTRIES-1] = valid_ff[0];
            end
            if (cnt_ff == SCAN_END) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            mem_we = 1'b1;
            state_in = ST_IDLE;
            if (hit_ff) begin
               mem_waddr = hit_idx_ff;
               mem_wdata = {line_region, line_off, new_desc, new_conf};
               for (int i = 0; i < STREAM_ENTRIES; i++) begin
                  if (IDX_W'(i) == hit_idx_ff) age_in[i] = '0;
                  else if (age_ff[i] < mine_ff) age_in[i] = age_ff[i] + 1'b1;
               end
               hit_desc_in = new_desc;
               n_in = n_sel[DEG_W-1:0];
               d_in = deg_type'(1);
               if (new_conf >= thr_ff && n_sel != '0) state_in = ST_EMIT;
            end else begin
               // miss: oldest entry wraps to age zero and takes the new stream
               mem_waddr = victim_ff;
               for (int i = 0; i < STREAM_ENTRIES; i++) begin
                  age_in[i] = (age_ff[i] == AGE_MAX) ? '0 : age_ff[i] + 1'b1;
                  if (IDX_W'(i) == victim_ff) valid_in[i] = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (load) begin
               rsp_valid_in = 1'b1;
               rsp_addr_in = {line_ff[LINE_ADDR_BITS-1:PAGE_BITS], target};
               rsp_last_in = (d_ff == n_ff);
               d_in = d_ff + 1'b1;
               if (d_ff == n_ff) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         hit_ff <= 1'b0;
         victim_seen_ff <= 1'b0;
         thr_ff <= THRESHOLD_RESET;
         deg_ff <= DEGREE_RESET;
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < STREAM_ENTRIES; i++) age_ff[i] <= IDX_W'(i);
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         hit_ff <= hit_in;
         victim_seen_ff <= victim_seen_in;
         thr_ff <= thr_in;
         deg_ff <= deg_in;
         valid_ff <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         age_ff <= age_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff <= line_in;
      hit_idx_ff <= hit_idx_in;
      mine_ff <= mine_in;
      hit_off_ff <= hit_off_in;
      hit_desc_ff <= hit_desc_in;
      hit_conf_ff <= hit_conf_in;
      victim_ff <= victim_in;
      n_ff <= n_in;
      d_ff <= d_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) entry_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= entry_mem[rd_addr];
   end

   for (genvar g = 0; g < STREAM_ENTRIES; g++) begin : g_age_zero
      assign age_zero[g] = (age_ff[g] == '0);
   end

   // ages stay a permutation: one entry is most recent between items
   a_age_perm: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> $onehot(age_zero))
      else $error("age row lost its single most-recent entry");

   // a miss always finds the oldest entry during the scan
   a_victim: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && !hit_ff) |-> victim_seen_ff)
      else $error("miss without a victim");

   // issue sequence stays within the computed prefetch count
   a_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (n_ff != '0 && d_ff <= n_ff && n_ff <= STREAM_DISTANCE))
      else $error("prefetch sequence out of range");

endmodule

/* sim/tb_top.sv */
// Testbench for stream_direction_prefetcher_unit: directed and random access
// streams are checked against a stream table predictor kept in the bench.
// Depends on sdp_pkg and the RTL top level.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sdp_pkg::*;

   // block geometry, matching the RTL defaults
   localparam int ENTRIES = 64;
   localparam int LINE_W = 58;
   localparam int PAGE_W = 6;
   localparam int REGION_W = 10;
   localparam int KEY_W = LINE_W - REGION_W;
   localparam int PAGE_SEL_W = REGION_W - PAGE_W;

   // leave margin for a table walk plus issue before csr writes
   localparam int SETTLE_CYCLES = 80;
   localparam int RUN_LIMIT = 2_000_000;
   localparam int ITEMS_PER_PHASE = 57;
   localparam int NUM_PHASES = 8;
   localparam int POOL = 96;

   typedef struct packed {
      logic [LINE_W-1:0] line;
      logic              last;
   } prefetch_type;

   typedef struct packed {
      conf_type threshold;
      deg_type  degree;
   } csr_setting_type;

   // random phases: threshold and degree extremes, degree above four included
   localparam csr_setting_type PHASES [NUM_PHASES] = '{
      '{3'd0, 3'd4}, '{3'd7, 3'd4}, '{3'd1, 3'd7}, '{3'd3, 3'd0},
      '{3'd0, 3'd1}, '{3'd2, 3'd3}, '{3'd4, 3'd5}, '{3'd1, 3'd4}
   };

   localparam logic [KEY_W-1:0] KEY_A = 48'h5A5A_0F0F_C3C3;
   localparam logic [KEY_W-1:0] KEY_B = 48'h0123_4567_89AB;

   // Opening items, run with threshold 2 and degree 2 out of reset.
   localparam logic [LINE_W-1:0] OPENING [23] = '{
      '0,                            // all-zero address, fresh entry
      '1,                            // all-ones address, fresh entry
      {KEY_A, 4'd0, 6'd10},          // new stream
      {KEY_A, 4'd0, 6'd11},          // ascending, confidence builds
      {KEY_A, 4'd0, 6'd12},
      {KEY_A, 4'd0, 6'd13},
      {KEY_A, 4'd0, 6'd14},
      {KEY_A, 4'd0, 6'd14},          // equal offset counts as descending
      {KEY_A, 4'd0, 6'd12},          // against the stream, confidence drains
      {KEY_A, 4'd0, 6'd10},
      {KEY_A, 4'd0, 6'd8},
      {KEY_A, 4'd0, 6'd6},           // confidence at zero: direction flips
      {KEY_A, 4'd0, 6'd4},
      {KEY_A, 4'd0, 6'd2},
      {KEY_A, 4'd0, 6'd1},           // targets below the page are dropped
      {KEY_A, 4'd0, 6'd0},           // hit above threshold with no target left
      {KEY_B, 4'd15, 6'd60},
      {KEY_B, 4'd15, 6'd61},
      {KEY_B, 4'd15, 6'd62},         // only one target left in the page
      {KEY_B, 4'd15, 6'd63},         // top of page, nothing issued
      58'h3FF_FFFF_FFFF_FFFE,        // all-ones region moving down
      {KEY_A, 4'd1, 6'd1},           // same region, next page
      {KEY_A, 4'd1, 6'd40}
   };

   // Stream table predictor plus the queue of prefetches still owed by the block.
   class prefetch_scoreboard;
      logic [KEY_W-1:0]  region_key [ENTRIES];
      logic [PAGE_W-1:0] last_offset [ENTRIES];
      bit                descending [ENTRIES];
      conf_type          confidence [ENTRIES];
      bit                in_use [ENTRIES];
      int unsigned       age [ENTRIES];
      conf_type          threshold;
      deg_type           degree;
      prefetch_type      expected_prefetches [$];
      int unsigned       errors;
      int unsigned       accesses;
      int unsigned       hits;
      int unsigned       prefetches;

      function new();
         for (int i = 0; i < ENTRIES; i++) begin
            region_key[i] = '0;
            last_offset[i] = '0;
            descending[i] = 1'b0;
            confidence[i] = '0;
            in_use[i] = 1'b0;
            age[i] = i;
         end
         threshold = THRESHOLD_RESET;
         degree = DEGREE_RESET;
         errors = 0;
         accesses = 0;
         hits = 0;
         prefetches = 0;
      endfunction

      function void set_register(csr_idx_type index, logic [DEG_W-1:0] value);
         case (index)
            CSR_THRESHOLD: threshold = value;
            CSR_DEGREE: degree = value;
            default: ;
         endcase
      endfunction

      // make slot the most recent entry
      function void promote(int slot);
         int unsigned mine;
         mine = age[slot];
         for (int i = 0; i < ENTRIES; i++)
            if (age[i] < mine) age[i]++;
         age[slot] = 0;
      endfunction

      function void note_access(logic [LINE_W-1:0] line);
         logic [PAGE_W-1:0] offset;
         logic [KEY_W-1:0]  key;
         int                slot;
         int                count;
         int                target;
         bit                moving_up;
         bit                agrees;
         prefetch_type      burst [$];
         prefetch_type      p;
         offset = line[PAGE_W-1:0];
         key = line[LINE_W-1:REGION_W];
         slot = -1;
         accesses++;
         for (int i = 0; i < ENTRIES; i++)
            if (slot < 0 && in_use[i] && region_key[i] == key) slot = i;
         if (slot < 0) begin
            // miss: every age moves up one, the one that wraps is replaced
            slot = 0;
            for (int i = 0; i < ENTRIES; i++) begin
               age[i]++;
               if (age[i] >= ENTRIES) begin
                  age[i] = 0;
                  slot = i;
               end
            end
            region_key[slot] = key;
            last_offset[slot] = offset;
            descending[slot] = 1'b0;
            confidence[slot] = '0;
            in_use[slot] = 1'b1;
            promote(slot);
            return;
         end
         hits++;
         moving_up = offset > last_offset[slot];
         agrees = moving_up ? !descending[slot] : descending[slot];
         if (agrees) begin
            if (confidence[slot] < CONF_MAX) confidence[slot]++;
         end else if (confidence[slot] > 0) begin
            confidence[slot]--;
         end else begin
            descending[slot] = !moving_up;
         end
         last_offset[slot] = offset;
         promote(slot);
         if (confidence[slot] < threshold) return;
         count = int'(degree < STREAM_DISTANCE ? degree : STREAM_DISTANCE);
         for (int d = 1; d <= count; d++) begin
            target = descending[slot] ? int'(offset) - d : int'(offset) + d;
            if (target >= 0 && target < (1 << PAGE_W)) begin
               p.line = {line[LINE_W-1:PAGE_W], PAGE_W'(target)};
               p.last = 1'b0;
               burst.push_back(p);
            end
         end
         if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
         foreach (burst[i]) expected_prefetches.push_back(burst[i]);
      endfunction

      function void check_prefetch(logic [LINE_W-1:0] line, logic last);
         prefetch_type want;
         if (expected_prefetches.size() == 0) begin
            errors++;
            $display("%0t: prefetch expected none, actual line %h last %b", $time, line, last);
            return;
         end
         want = expected_prefetches.pop_front();
         prefetches++;
         if (line !== want.line) begin
            errors++;
            $display("%0t: prefetch line expected %h actual %h", $time, want.line, line);
         end
         if (last !== want.last) begin
            errors++;
            $display("%0t: last flag expected %b actual %b", $time, want.last, last);
         end
      endfunction

      function int unsigned pending();
         return expected_prefetches.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [LINE_W-1:0] req_line_addr;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [LINE_W-1:0] rsp_prefetch_line_addr;
   logic              rsp_last;
   logic              csr_valid;
   logic              csr_ready;
   csr_idx_type       csr_index;
   logic [DEG_W-1:0]  csr_wdata;

   // no idling on either side once set
   bit quiet_tail = 1'b0;

   prefetch_scoreboard sb = new();

   // synthetic streams: region, page within the region, offset and direction
   logic [KEY_W-1:0]      pool_key [POOL];
   logic [PAGE_SEL_W-1:0] pool_page [POOL];
   int                    pool_offset [POOL];
   bit                    pool_down [POOL];

   stream_direction_prefetcher_unit dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Both channels are sampled at the edge: results are checked before the
   // access accepted at the same edge is noted, which cannot owe anything yet.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) sb.check_prefetch(rsp_prefetch_line_addr, rsp_last);
         if (req_valid && !req_stall) sb.note_access(req_line_addr);
      end
   end

   // Receiver back-pressure comes in bursts, with clear runs between.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Valid stays high across back-to-back items; only the caller lowers it.
   task automatic send_access(logic [LINE_W-1:0] line);
      req_valid <= 1'b1;
      req_line_addr <= line;
      do @(posedge clock); while (req_stall);
   endtask

   // odds of 0 means this stretch runs without sender gaps
   task automatic sender_gap(int unsigned odds);
      if (!quiet_tail && odds != 0 && $urandom_range(1, odds) == 1) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
   endtask

   // Hold the sender until every owed prefetch is back, then let any item that
   // issues nothing finish its table walk.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // csr_valid stays high across back-to-back writes; caller drops it
   task automatic write_register(csr_idx_type index, logic [DEG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(index, value);
   endtask

   function automatic void seed_streams(int unsigned live);
      for (int i = 0; i < live; i++) begin
         pool_key[i] = KEY_W'({$urandom, $urandom});
         pool_page[i] = PAGE_SEL_W'($urandom);
         pool_offset[i] = int'($urandom_range(0, (1 << PAGE_W) - 1));
         pool_down[i] = $urandom_range(0, 1) == 1;
      end
   endfunction

   // Advance one stream by 0 to 3 lines; mostly steady direction with an
   // occasional turn or page jump, crossing into the neighbor page at the edge.
   function automatic logic [LINE_W-1:0] next_stream_line(int unsigned live);
      int unsigned s;
      int          step;
      s = $urandom_range(0, live - 1);
      case ($urandom_range(0, 15))
         0: pool_down[s] = !pool_down[s];
         1: pool_page[s] = PAGE_SEL_W'($urandom);
         default: ;
      endcase
      step = ($urandom_range(0, 7) == 0) ? 0 : int'($urandom_range(1, 3));
      pool_offset[s] += pool_down[s] ? -step : step;
      if (pool_offset[s] < 0 || pool_offset[s] >= (1 << PAGE_W)) begin
         if (pool_down[s]) pool_page[s]--;
         else pool_page[s]++;
         pool_offset[s] &= (1 << PAGE_W) - 1;
      end
      return {pool_key[s], pool_page[s], PAGE_W'(pool_offset[s])};
   endfunction

   initial begin
      int unsigned live;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_line_addr <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_THRESHOLD;
      csr_wdata <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed opening at the reset settings
      foreach (OPENING[i]) begin
         send_access(OPENING[i]);
         sender_gap(3);
      end

      // Random phases. Even phases reuse a few streams so confidence saturates;
      // odd ones run more streams than table entries so LRU replacement churns.
      for (int p = 0; p < NUM_PHASES; p++) begin
         wait_idle();
         write_register(CSR_THRESHOLD, PHASES[p].threshold);
         write_register(CSR_DEGREE, PHASES[p].degree);
         csr_valid <= 1'b0;
         live = (p % 2 == 0) ? 6 : 90;
         seed_streams(live);
         quiet_tail = (p == NUM_PHASES - 1);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // one in five is a fully random address
            if ($urandom_range(0, 4) == 0) send_access(LINE_W'({$urandom, $urandom}));
            else send_access(next_stream_line(live));
            sender_gap((p % 3 == 1) ? 0 : 4);
         end
      end

      wait_idle();
      $display("run covered %0d accesses (%0d table hits) and %0d checked prefetches",
               sb.accesses, sb.hits, sb.prefetches);
      $display("over %0d threshold/degree settings with stalls and gaps on both sides",
               NUM_PHASES + 1);
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // hang guard: a missing prefetch or a stuck handshake ends here
   initial begin
      #(RUN_LIMIT);
      $display("simulation failed");
      $finish;
   end

endmodule
